/* rtl/positional_list_engine_defines.svh */
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
`define PLE_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PLE_ASSERT(label, cond, msg)
`define PLE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/ple_pkg.sv */
// ----------------------------------------------------------------------------
// Positional list engine package
// Sizes, codes and the command and status bundles shared by the modules.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam int OP_W       = 3;
  localparam int VAL_W      = 32;
  localparam int POS_W      = 6;
  localparam int STAT_W     = 2;
  localparam int LEN_W      = 7;

  localparam int IN_FIELDS_W  = OP_W + VAL_W + POS_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STAT_W + VAL_W + LEN_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT   = 3'd0,
    OP_PUSH_BACK    = 3'd1,
    OP_INSERT_AFTER = 3'd2,
    OP_POP_FRONT    = 3'd3,
    OP_POP_BACK     = 3'd4,
    OP_REMOVE_AT    = 3'd5,
    OP_READ_AT      = 3'd6
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_INSERT,
    KIND_REMOVE,
    KIND_READ
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT,
    ST_COMMIT,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic rd_issue;
    logic step;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  err;
    logic  more;
    logic  pend_busy;
    logic  out_free;
  } sts_t;

endpackage

/* rtl/ple_ctrl.sv */
// ----------------------------------------------------------------------------
// Positional list engine controller
// Sequences decode, entry moves, commit and result hand-off for each item.
// ----------------------------------------------------------------------------
module ple_ctrl
  import ple_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.err) begin
          state_next = ST_REPORT;
        end else begin
          unique case (sts.kind)
            KIND_INSERT, KIND_REMOVE: state_next = ST_SHIFT;
            default:                  state_next = ST_REPORT;
          endcase
        end
      end
      ST_SHIFT: begin
        if (!sts.more) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!sts.pend_busy) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DECODE: begin
        cmd.decode   = 1'b1;
        cmd.rd_issue = !sts.err && (sts.kind == KIND_READ);
      end
      ST_SHIFT:  cmd.step   = sts.more;
      ST_COMMIT: cmd.commit = !sts.pend_busy;
      ST_REPORT: cmd.emit   = sts.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/ple_dp.sv */
// ----------------------------------------------------------------------------
// Positional list engine datapath
// Entry memory, count, move cursor, operation decode and result register.
// ----------------------------------------------------------------------------
`include "positional_list_engine_defines.svh"

module ple_dp
  import ple_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  cmd_t                   cmd,
  output sts_t                   sts
);

  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rdata;

  op_t              operation;
  logic [VAL_W-1:0] value;
  logic [POS_W-1:0] position;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cursor;
  logic [CNT_W-1:0] target;
  kind_t            kind_q;
  stat_t            stat_q;
  logic             pend_valid;
  logic [IDX_W-1:0] pend_addr;

  logic [CNT_W-1:0] pos_ext;
  logic             pos_in;
  logic             full;
  logic             empty;
  kind_t            dec_kind;
  stat_t            dec_stat;
  logic [CNT_W-1:0] dec_target;
  logic [CNT_W-1:0] cursor_dn;
  logic [CNT_W-1:0] cursor_up;
  logic             shift_up;

  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic                  re;
  logic [IDX_W-1:0]      raddr;
  logic [VAL_W-1:0]      rd_val;

  always_comb begin
    pos_ext    = CNT_W'(position);
    pos_in     = pos_ext < count;
    full       = count == CNT_W'(CAPACITY);
    empty      = count == '0;
    dec_kind   = KIND_NONE;
    dec_stat   = STAT_DONE;
    dec_target = '0;
    unique case (operation)
      OP_PUSH_FRONT: begin
        dec_kind = KIND_INSERT;
        if (full) dec_stat = STAT_FULL;
      end
      OP_PUSH_BACK: begin
        dec_kind   = KIND_INSERT;
        dec_target = count;
        if (full) dec_stat = STAT_FULL;
      end
      OP_INSERT_AFTER: begin
        dec_kind   = KIND_INSERT;
        dec_target = pos_in ? pos_ext + 1'b1 : count;
        if (full) dec_stat = STAT_FULL;
      end
      OP_POP_FRONT: begin
        dec_kind = KIND_REMOVE;
        if (empty) dec_stat = STAT_MISS;
      end
      OP_POP_BACK: begin
        dec_kind   = KIND_REMOVE;
        dec_target = count - 1'b1;
        if (empty) dec_stat = STAT_MISS;
      end
      OP_REMOVE_AT: begin
        dec_kind   = KIND_REMOVE;
        dec_target = pos_ext;
        if (!pos_in) dec_stat = STAT_MISS;
      end
      OP_READ_AT: begin
        dec_kind   = KIND_READ;
        dec_target = pos_ext;
        if (!pos_in) dec_stat = STAT_MISS;
      end
      default: begin
        dec_kind = KIND_NONE;
        dec_stat = STAT_MISS;
      end
    endcase
  end

  assign cursor_dn = cursor - 1'b1;
  assign cursor_up = cursor + 1'b1;
  assign shift_up  = kind_q == KIND_INSERT;

  assign sts.kind      = dec_kind;
  assign sts.err       = dec_stat != STAT_DONE;
  assign sts.more      = shift_up ? (cursor > target) : (cursor_up < count);
  assign sts.pend_busy = pend_valid;
  assign sts.out_free  = !m_tvalid || m_tready;

  always_comb begin
    we    = pend_valid || (cmd.commit && shift_up);
    waddr = pend_valid ? pend_addr : target[IDX_W-1:0];
    wdata = pend_valid ? rdata : VALUE_BITS'(value);
    re    = cmd.step || cmd.rd_issue;
    if (cmd.rd_issue) begin
      raddr = IDX_W'(position);
    end else if (shift_up) begin
      raddr = cursor_dn[IDX_W-1:0];
    end else begin
      raddr = cursor_up[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      pend_valid <= cmd.step;
      if (cmd.commit) begin
        count <= shift_up ? count + 1'b1 : count - 1'b1;
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign rd_val = (kind_q == KIND_READ && stat_q == STAT_DONE) ? VAL_W'(rdata) : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      operation <= op_t'(s_tdata[OP_W-1:0]);
      value     <= s_tdata[OP_W +: VAL_W];
      position  <= s_tdata[OP_W+VAL_W +: POS_W];
    end
    if (cmd.decode) begin
      kind_q <= dec_kind;
      stat_q <= dec_stat;
      target <= dec_target;
      cursor <= (dec_kind == KIND_INSERT) ? count : dec_target;
    end
    if (cmd.step) begin
      pend_addr <= cursor[IDX_W-1:0];
      cursor    <= shift_up ? cursor_dn : cursor_up;
    end
    if (cmd.emit) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, (count == '0), LEN_W'(count), rd_val, stat_q};
    end
  end

  `PLE_ASSERT(a_count_range, count <= CNT_W'(CAPACITY), "entry count above capacity")
  `PLE_ASSERT(a_no_wr_clash, !(pend_valid && cmd.commit), "commit during a pending move")
  `PLE_ASSERT_NEXT(a_count_hold, !cmd.commit, count == $past(count), "count moved without commit")
  `PLE_ASSERT(a_no_overrun, !(cmd.emit && m_tvalid && !m_tready), "result overwritten before taken")

endmodule

/* rtl/positional_list_engine.sv */
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed values with positional insert, remove and read.
// ----------------------------------------------------------------------------
// The block handles one item at a time and returns exactly one result per
// item. Entries live in a single memory with one write and one registered
// read port, and positional inserts and removes move the entries behind the
// affected position one per cycle through that memory. A successful insert or
// remove moves up to 63 entries, one at the tail moves none, and reads and
// failed operations move none either. The next item is taken only after
// the result of the current one is loaded into the output register, where
// it waits until it is taken; the next result cannot be loaded before then,
// so a stalled output holds back the acceptance of further items.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // operation[2:0], value[34:3], position[40:35], zero padding above
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // status[1:0], read_value[33:2], length[40:34], is_empty[41], zero padding above
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  cmd_t cmd;
  sts_t sts;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ple_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives list operations into the slave stream and checks every result on the
// master stream against its table entry or an in-bench list that replays
// each accepted item. A short table of directed items comes first. It
// covers the empty list, clamped inserts, out-of-range positions and the
// unused operation code. Random segments follow that fill the list to
// capacity and drain it again. Both sides stall at random throughout.
// ----------------------------------------------------------------------------
module tb_top;
  import ple_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int N_DIRECTED   = 23;
  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
  } list_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  read_value;
    logic [LEN_W-1:0]  length;
    logic              is_empty;
  } list_reply_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [VAL_W-1:0]  value;
    logic [POS_W-1:0]  pos;
    logic              typed;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;
  } dir_row_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_t;

  // Rows marked typed carry the expected status and length; read_value is
  // zero for all of them. The other rows are checked by the list model.
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_POP_FRONT,    32'h0000_0000, 6'd0,  1'b1, STAT_MISS, 7'd0},
    '{OP_POP_BACK,     32'h0000_0000, 6'd0,  1'b1, STAT_MISS, 7'd0},
    '{OP_REMOVE_AT,    32'h0000_0000, 6'd0,  1'b1, STAT_MISS, 7'd0},
    '{OP_READ_AT,      32'h0000_0000, 6'd0,  1'b1, STAT_MISS, 7'd0},
    '{OP_UNUSED,       32'h0000_0000, 6'd0,  1'b1, STAT_MISS, 7'd0},
    '{OP_INSERT_AFTER, 32'h7FFF_FFFF, 6'd63, 1'b1, STAT_DONE, 7'd1},
    '{OP_PUSH_FRONT,   32'h8000_0000, 6'd0,  1'b1, STAT_DONE, 7'd2},
    '{OP_PUSH_BACK,    32'hFFFF_FFFF, 6'd0,  1'b1, STAT_DONE, 7'd3},
    '{OP_PUSH_BACK,    32'h0000_0000, 6'd63, 1'b1, STAT_DONE, 7'd4},
    '{OP_INSERT_AFTER, 32'h5555_5555, 6'd63, 1'b1, STAT_DONE, 7'd5},
    '{OP_INSERT_AFTER, 32'hAAAA_AAAA, 6'd0,  1'b1, STAT_DONE, 7'd6},
    '{OP_READ_AT,      32'h0000_0000, 6'd0,  1'b0, STAT_DONE, 7'd0},
    '{OP_READ_AT,      32'hFFFF_FFFF, 6'd1,  1'b0, STAT_DONE, 7'd0},
    '{OP_READ_AT,      32'h0000_0000, 6'd5,  1'b0, STAT_DONE, 7'd0},
    '{OP_READ_AT,      32'h0000_0000, 6'd6,  1'b1, STAT_MISS, 7'd6},
    '{OP_READ_AT,      32'h0000_0000, 6'd63, 1'b1, STAT_MISS, 7'd6},
    '{OP_REMOVE_AT,    32'h0000_0000, 6'd63, 1'b1, STAT_MISS, 7'd6},
    '{OP_REMOVE_AT,    32'h0000_0000, 6'd2,  1'b0, STAT_DONE, 7'd0},
    '{OP_UNUSED,       32'hFFFF_FFFF, 6'd63, 1'b1, STAT_MISS, 7'd5},
    '{OP_POP_FRONT,    32'h0000_0000, 6'd0,  1'b0, STAT_DONE, 7'd0},
    '{OP_POP_BACK,     32'h0000_0000, 6'd0,  1'b0, STAT_DONE, 7'd0},
    '{OP_REMOVE_AT,    32'h0000_0000, 6'd0,  1'b0, STAT_DONE, 7'd0},
    '{OP_READ_AT,      32'h0000_0000, 6'd0,  1'b0, STAT_DONE, 7'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // operation[2:0], value[34:3], position[40:35], zero padding above
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // status[1:0], read_value[33:2], length[40:34], is_empty[41], zero padding above
  logic [OUT_TDATA_W-1:0] m_tdata;

  logic [VAL_W-1:0] list_vals [CAPACITY];
  int               list_len = 0;
  list_reply_t      replies_q [$];

  int  errors       = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  full_drops   = 0;
  int  misses       = 0;
  int  peak_len     = 0;
  int  quiet_cycles = 0;
  bit  tx_quiet     = 1'b0;

  positional_list_engine DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic list_reply_t apply_list_op(list_cmd_t c);
    list_reply_t r;
    int          slot;
    int          take;
    int          i;
    r    = '0;
    take = -1;
    r.status = STAT_DONE;
    case (c.op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AFTER: begin
        if (list_len >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          if (c.op == OP_PUSH_FRONT) begin
            slot = 0;
          end else if (c.op == OP_PUSH_BACK || list_len == 0) begin
            slot = list_len;
          end else begin
            slot = ((int'(c.pos) < list_len) ? int'(c.pos) : list_len - 1) + 1;
          end
          for (i = list_len; i > slot; i--) list_vals[i] = list_vals[i-1];
          list_vals[slot] = c.value;
          list_len++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (list_len == 0) r.status = STAT_MISS;
        else take = (c.op == OP_POP_FRONT) ? 0 : list_len - 1;
      end
      OP_REMOVE_AT: begin
        if (int'(c.pos) >= list_len) r.status = STAT_MISS;
        else take = int'(c.pos);
      end
      OP_READ_AT: begin
        if (int'(c.pos) >= list_len) r.status = STAT_MISS;
        else r.read_value = list_vals[c.pos];
      end
      default: r.status = STAT_MISS;
    endcase
    if (take >= 0) begin
      for (i = take; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
      list_len--;
    end
    r.length   = LEN_W'(list_len);
    r.is_empty = (list_len == 0);
    return r;
  endfunction

  function automatic list_cmd_t make_cmd(mix_t mode);
    list_cmd_t c;
    int        r;
    r = $urandom_range(0, 9);
    case (mode)
      MODE_FILL: begin
        if (r < 8) c.op = OP_W'($urandom_range(0, 2));
        else if (r == 8) c.op = OP_READ_AT;
        else c.op = OP_W'($urandom_range(0, 7));
      end
      MODE_DRAIN: begin
        if (r < 7) c.op = OP_W'($urandom_range(3, 5));
        else if (r < 9) c.op = OP_READ_AT;
        else c.op = OP_W'($urandom_range(0, 7));
      end
      default: begin
        if ($urandom_range(0, 15) == 0) c.op = OP_UNUSED;
        else c.op = OP_W'($urandom_range(0, 6));
      end
    endcase
    if (list_len > 0 && $urandom_range(0, 3) != 0) begin
      c.pos = POS_W'($urandom_range(0, list_len - 1));
    end else begin
      c.pos = POS_W'($urandom_range(0, 63));
    end
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: c.value = 32'h8000_0000;
        1: c.value = 32'h7FFF_FFFF;
        2: c.value = 32'h0000_0000;
        default: c.value = 32'hFFFF_FFFF;
      endcase
    end else begin
      c.value = $urandom;
    end
    return c;
  endfunction

  task automatic send_cmd(input list_cmd_t c, input bit typed, input list_reply_t fixed);
    int          gap;
    list_reply_t predicted;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, c.pos, c.value, c.op};
    do @(posedge clk); while (!s_tready);
    predicted = apply_list_op(c);
    replies_q.push_back(typed ? fixed : predicted);
    items_sent++;
    if (predicted.status == STAT_FULL) full_drops++;
    if (predicted.status == STAT_MISS) misses++;
    if (list_len > peak_len) peak_len = list_len;
  endtask

  initial begin
    list_cmd_t   row_cmd;
    list_reply_t row_reply;
    mix_t        mode;
    int          seg;
    int          seg_left;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[k]) begin
      row_cmd.op          = DIRECTED[k].op;
      row_cmd.value       = DIRECTED[k].value;
      row_cmd.pos         = DIRECTED[k].pos;
      row_reply.status     = DIRECTED[k].status;
      row_reply.read_value = '0;
      row_reply.length     = DIRECTED[k].length;
      row_reply.is_empty   = (DIRECTED[k].length == 0);
      send_cmd(row_cmd, DIRECTED[k].typed, row_reply);
    end
    seg = 0;
    while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
      if (seg == 0) mode = MODE_FILL;
      else if (seg == 1) mode = MODE_DRAIN;
      else mode = mix_t'($urandom_range(0, 2));
      seg_left = (seg < 2) ? 120 : $urandom_range(40, 120);
      tx_quiet = ($urandom_range(0, 3) == 0);
      repeat (seg_left) send_cmd(make_cmd(mode), 1'b0, '0);
      seg++;
    end
    s_tvalid <= 1'b0;
    while (replies_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items: %0d misses on empty list, bad position or unused code, %0d inserts dropped on a full list.",
             items_sent, misses, full_drops);
    $display("The list reached %0d of %0d entries; %0d results checked.",
             peak_len, CAPACITY, results_seen);
    if (errors == 0) begin
      $display("** positional_list_engine: PASSED **");
    end else begin
      $display("** positional_list_engine: FAILED **");
    end
    $finish;
  end

  initial begin
    int          gap;
    bit          rx_quiet;
    list_reply_t got;
    list_reply_t want;
    rx_quiet = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      gap = rx_quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results_seen++;
      got.status     = m_tdata[1:0];
      got.read_value = m_tdata[33:2];
      got.length     = m_tdata[40:34];
      got.is_empty   = m_tdata[41];
      if (replies_q.size() == 0) begin
        $error("Result with no item waiting: tdata %h", m_tdata);
        errors++;
      end else begin
        want = replies_q.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          errors++;
        end
        if (got.read_value !== want.read_value) begin
          $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
          errors++;
        end
        if (got.length !== want.length) begin
          $error("length: expected %0d, actual %0d", want.length, got.length);
          errors++;
        end
        if (got.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** positional_list_engine: FAILED **");
        $finish;
      end
    end
  end

endmodule
